// ===== rtl/core/core_hotplug_governor_assert.svh =====
// assertion macros for the hotplug governor rtl
`ifndef CORE_HOTPLUG_GOVERNOR_ASSERT_SVH
`define CORE_HOTPLUG_GOVERNOR_ASSERT_SVH
`ifndef SYNTHESIS
`define CHG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property violated");
`define CHG_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define CHG_ASSERT(lbl, clk, rst_n, prop)
`define CHG_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/chg_pkg.sv =====
// shared types and constants of the hotplug governor
package chg_pkg;

    localparam int MASK_W    = 8;
    localparam int ID_W      = 3;
    localparam int LOAD_W    = 7;
    localparam int FREQ_W    = 22;
    localparam int SUM_W     = 10;
    localparam int CNT_W     = 4;
    localparam int WAIT_W    = 6;
    localparam int PRIO_W    = 8;
    localparam int PRIOS_W   = 64;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 24;

    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_UP_LOAD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CORES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CORES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_WAIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_WAIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITIES = 3'd5;

    localparam logic [LOAD_W-1:0]  RST_UP_LOAD    = 7'd80;
    localparam logic [CNT_W-1:0]   RST_MIN_CORES  = 4'd2;
    localparam logic [CNT_W-1:0]   RST_MAX_CORES  = 4'd8;
    localparam logic [WAIT_W-1:0]  RST_UP_WAIT    = 6'd2;
    localparam logic [WAIT_W-1:0]  RST_DOWN_WAIT  = 6'd6;
    localparam logic [PRIOS_W-1:0] RST_PRIORITIES = 64'h5050_5050_5050_5050;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_ONLINE  = 2'd1,
        ACT_OFFLINE = 2'd2
    } plug_action_t;

    typedef struct packed {
        logic accum;
        logic div_load;
        logic div_step;
        logic decide;
    } chg_cmd_t;

    typedef struct packed {
        logic out_stall;
    } chg_sts_t;

endpackage

// ===== rtl/core/chg_ctrl.sv =====
// controller state machine sequencing accumulate, divide and decide
`include "core_hotplug_governor_assert.svh"

module chg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    output chg_pkg::chg_cmd_t cmd,
    input  chg_pkg::chg_sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_DECIDE
    } state_t;

    state_t                      state_reg, state_next;
    logic [chg_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accum = s_tvalid && ready_reg;
                if (s_tvalid && ready_reg && s_tlast)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == chg_pkg::STEP_W'(chg_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DECIDE:
            begin
                if (!sts.out_stall)
                begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

    `CHG_NEVER(a_decide_into_stall, clk, rst_n, cmd.decide && sts.out_stall)
    `CHG_ASSERT(a_last_closes_input, clk, rst_n, s_tvalid && s_tready && s_tlast |=> !s_tready)
    `CHG_ASSERT(a_step_in_range, clk, rst_n,
        step_reg <= chg_pkg::STEP_W'(chg_pkg::DIV_STEPS - 1))

endmodule

// ===== rtl/core/chg_datapath.sv =====
// datapath: settings, tick accumulators, serial divider and plug decision
`include "core_hotplug_governor_assert.svh"

module chg_datapath #(
    parameter int NUM_CORES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [chg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [chg_pkg::PRIOS_W-1:0]       cfg_data,
    input  logic [chg_pkg::IN_W-1:0]          s_tdata,
    input  chg_pkg::chg_cmd_t                 cmd,
    output chg_pkg::chg_sts_t                 sts,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [chg_pkg::OUT_W-1:0]         m_tdata
);

    localparam logic [chg_pkg::MASK_W-1:0] AllOnline =
        chg_pkg::MASK_W'((9'd1 << NUM_CORES) - 9'd1);

    // settings
    logic [chg_pkg::LOAD_W-1:0]  up_thr_reg, up_thr_next;
    logic [chg_pkg::CNT_W-1:0]   min_cores_reg, min_cores_next;
    logic [chg_pkg::CNT_W-1:0]   max_cores_reg, max_cores_next;
    logic [chg_pkg::WAIT_W-1:0]  up_ticks_reg, up_ticks_next;
    logic [chg_pkg::WAIT_W-1:0]  down_ticks_reg, down_ticks_next;
    logic [chg_pkg::PRIOS_W-1:0] prios_reg, prios_next;

    // governor state
    logic [chg_pkg::MASK_W-1:0]  mask_reg, mask_next;
    logic [chg_pkg::WAIT_W-1:0]  up_cnt_reg, up_cnt_next;
    logic [chg_pkg::WAIT_W-1:0]  down_cnt_reg, down_cnt_next;
    logic [chg_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [chg_pkg::FREQ_W-1:0]  low_freq_reg, low_freq_next;
    logic [chg_pkg::ID_W-1:0]    low_core_reg, low_core_next;
    logic [chg_pkg::PRIO_W-1:0]  top_prio_reg, top_prio_next;
    logic [chg_pkg::ID_W-1:0]    top_core_reg, top_core_next;
    logic                        tie_reg, tie_next;

    // divider
    logic [chg_pkg::SUM_W-1:0]   quo_reg, quo_next;
    logic [chg_pkg::CNT_W-1:0]   rem_reg, rem_next;

    // result register
    logic                        out_valid_reg, out_valid_next;
    chg_pkg::plug_action_t       action_reg, action_next;
    logic [chg_pkg::ID_W-1:0]    target_reg, target_next;
    logic [chg_pkg::MASK_W-1:0]  out_mask_reg, out_mask_next;
    logic [chg_pkg::LOAD_W-1:0]  avg_reg, avg_next;

    logic [chg_pkg::ID_W-1:0]    core_id;
    logic [chg_pkg::LOAD_W-1:0]  core_load;
    logic [chg_pkg::FREQ_W-1:0]  core_freq_khz;
    logic [chg_pkg::PRIO_W-1:0]  thr;
    logic                        sample_ok;
    logic [chg_pkg::CNT_W-1:0]   online_cnt;
    logic [chg_pkg::CNT_W:0]     partial;
    logic [chg_pkg::WAIT_W-1:0]  up_bump;
    logic [chg_pkg::WAIT_W-1:0]  down_bump;
    logic [chg_pkg::LOAD_W-1:0]  avg;
    logic                        add_cond;
    logic                        rem_cond;
    logic                        free_found;
    logic [chg_pkg::ID_W-1:0]    free_core;
    logic [chg_pkg::ID_W-1:0]    drop_core;

    assign core_id       = s_tdata[2:0];
    assign core_load     = s_tdata[9:3];
    assign core_freq_khz = s_tdata[31:10];
    assign thr           = prios_reg[{core_id, 3'b000} +: chg_pkg::PRIO_W];
    assign sample_ok     = (4'(core_id) < 4'(NUM_CORES)) && mask_reg[core_id];

    always_comb
    begin
        online_cnt = '0;
        for (int i = 0; i < chg_pkg::MASK_W; i++)
        begin
            online_cnt = online_cnt + chg_pkg::CNT_W'(mask_reg[i]);
        end
    end

    // first offline core above core zero
    always_comb
    begin
        free_found = 1'b0;
        free_core  = '0;
        for (int i = 1; i < NUM_CORES; i++)
        begin
            if (!free_found && !mask_reg[i])
            begin
                free_found = 1'b1;
                free_core  = chg_pkg::ID_W'(i);
            end
        end
    end

    assign partial   = {rem_reg, quo_reg[chg_pkg::SUM_W-1]};
    assign up_bump   = (up_cnt_reg < up_ticks_reg) ? up_cnt_reg + 1'b1 : up_cnt_reg;
    assign down_bump = (down_cnt_reg < down_ticks_reg) ? down_cnt_reg + 1'b1 : down_cnt_reg;
    assign avg       = (online_cnt == '0) ? '0 : quo_reg[chg_pkg::LOAD_W-1:0];
    assign add_cond  = ((avg >= up_thr_reg) && (up_bump >= up_ticks_reg))
                       || (online_cnt < min_cores_reg);
    assign rem_cond  = (down_bump >= down_ticks_reg) || (online_cnt > max_cores_reg);
    assign drop_core = tie_reg ? low_core_reg : top_core_reg;

    always_comb
    begin
        up_thr_next     = up_thr_reg;
        min_cores_next  = min_cores_reg;
        max_cores_next  = max_cores_reg;
        up_ticks_next   = up_ticks_reg;
        down_ticks_next = down_ticks_reg;
        prios_next      = prios_reg;
        mask_next       = mask_reg;
        up_cnt_next     = up_cnt_reg;
        down_cnt_next   = down_cnt_reg;
        sum_next        = sum_reg;
        low_freq_next   = low_freq_reg;
        low_core_next   = low_core_reg;
        top_prio_next   = top_prio_reg;
        top_core_next   = top_core_reg;
        tie_next        = tie_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        action_next     = action_reg;
        target_next     = target_reg;
        out_mask_next   = out_mask_reg;
        avg_next        = avg_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                chg_pkg::CFG_UP_LOAD:    up_thr_next     = cfg_data[chg_pkg::LOAD_W-1:0];
                chg_pkg::CFG_MIN_CORES:  min_cores_next  = cfg_data[chg_pkg::CNT_W-1:0];
                chg_pkg::CFG_MAX_CORES:  max_cores_next  = cfg_data[chg_pkg::CNT_W-1:0];
                chg_pkg::CFG_UP_WAIT:    up_ticks_next   = cfg_data[chg_pkg::WAIT_W-1:0];
                chg_pkg::CFG_DOWN_WAIT:  down_ticks_next = cfg_data[chg_pkg::WAIT_W-1:0];
                chg_pkg::CFG_PRIORITIES: prios_next      = cfg_data;
                default:                 prios_next      = prios_reg;
            endcase
        end

        if (cmd.accum && sample_ok)
        begin
            sum_next = sum_reg + chg_pkg::SUM_W'(core_load);
            if ((core_id == '0) || (thr == top_prio_reg))
            begin
                top_prio_next = thr;
                top_core_next = core_id;
                tie_next      = 1'b1;
            end
            else if (thr > top_prio_reg)
            begin
                top_prio_next = thr;
                top_core_next = core_id;
                tie_next      = 1'b0;
            end
            if ((core_id != '0) && ((low_core_reg == '0) || (low_freq_reg > core_freq_khz)))
            begin
                low_freq_next = core_freq_khz;
                low_core_next = core_id;
            end
        end

        if (cmd.div_load)
        begin
            quo_next = sum_reg;
            rem_next = '0;
        end

        // restoring division, one quotient bit a cycle
        if (cmd.div_step)
        begin
            if (partial >= {1'b0, online_cnt})
            begin
                rem_next = chg_pkg::CNT_W'(partial - {1'b0, online_cnt});
                quo_next = {quo_reg[chg_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[chg_pkg::CNT_W-1:0];
                quo_next = {quo_reg[chg_pkg::SUM_W-2:0], 1'b0};
            end
        end

        if (cmd.decide)
        begin
            up_cnt_next   = up_bump;
            down_cnt_next = down_bump;
            action_next   = chg_pkg::ACT_NONE;
            target_next   = '0;
            if (add_cond)
            begin
                if ((online_cnt < max_cores_reg) && free_found)
                begin
                    mask_next   = mask_reg | (chg_pkg::MASK_W'(1) << free_core);
                    action_next = chg_pkg::ACT_ONLINE;
                    target_next = free_core;
                end
                up_cnt_next   = '0;
                down_cnt_next = '0;
            end
            else if (rem_cond)
            begin
                if (online_cnt > min_cores_reg)
                begin
                    mask_next   = mask_reg & ~(chg_pkg::MASK_W'(1) << drop_core) & AllOnline;
                    action_next = chg_pkg::ACT_OFFLINE;
                    target_next = drop_core;
                end
                up_cnt_next   = '0;
                down_cnt_next = '0;
            end
            out_mask_next  = mask_next;
            avg_next       = avg;
            out_valid_next = 1'b1;
            sum_next       = '0;
            low_freq_next  = '1;
            low_core_next  = '0;
            top_prio_next  = '0;
            top_core_next  = '0;
            tie_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_thr_reg     <= chg_pkg::RST_UP_LOAD;
            min_cores_reg  <= chg_pkg::RST_MIN_CORES;
            max_cores_reg  <= chg_pkg::RST_MAX_CORES;
            up_ticks_reg   <= chg_pkg::RST_UP_WAIT;
            down_ticks_reg <= chg_pkg::RST_DOWN_WAIT;
            prios_reg      <= chg_pkg::RST_PRIORITIES;
            mask_reg       <= AllOnline;
            up_cnt_reg     <= '0;
            down_cnt_reg   <= '0;
            sum_reg        <= '0;
            low_freq_reg   <= '1;
            low_core_reg   <= '0;
            top_prio_reg   <= '0;
            top_core_reg   <= '0;
            tie_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            up_thr_reg     <= up_thr_next;
            min_cores_reg  <= min_cores_next;
            max_cores_reg  <= max_cores_next;
            up_ticks_reg   <= up_ticks_next;
            down_ticks_reg <= down_ticks_next;
            prios_reg      <= prios_next;
            mask_reg       <= mask_next;
            up_cnt_reg     <= up_cnt_next;
            down_cnt_reg   <= down_cnt_next;
            sum_reg        <= sum_next;
            low_freq_reg   <= low_freq_next;
            low_core_reg   <= low_core_next;
            top_prio_reg   <= top_prio_next;
            top_core_reg   <= top_core_next;
            tie_reg        <= tie_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        action_reg   <= action_next;
        target_reg   <= target_next;
        out_mask_reg <= out_mask_next;
        avg_reg      <= avg_next;
    end

    assign sts.out_stall = out_valid_reg && !m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {4'b0000, avg_reg, out_mask_reg, target_reg, action_reg};

    `CHG_NEVER(a_mask_in_range, clk, rst_n, (mask_reg & ~AllOnline) != '0)
    `CHG_ASSERT(a_decide_gives_result, clk, rst_n, cmd.decide |=> m_tvalid)
    `CHG_ASSERT(a_idle_action_no_target, clk, rst_n,
        m_tvalid && (action_reg == chg_pkg::ACT_NONE) |-> target_reg == '0)

endmodule

// ===== rtl/core/core_hotplug_governor.sv =====
// top level of the per-tick core hotplug governor
//
//  group    dir  signals                     contents
//  s_       in   tvalid tready tdata tlast   one core sample, tlast marks last of tick
//  m_       out  tvalid tready tdata         one plug decision per tick
//  cfg_     in   valid ready index data      settings write, always ready
//
// a sample that is not the last of its tick leaves s_tready high for the next sample
// the last sample is followed by load, 10 steps of the serial divider, then decide
// the decide step waits while the result register is still held by the sink
// reset restores every setting to its default and brings all cores online
// a result may wait in its register while the next tick's samples are taken

module core_hotplug_governor #(
    parameter int NUM_CORES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [chg_pkg::IN_W-1:0]      s_tdata,   // core_id, core_load, core_freq_khz
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // plug_action, target_core, online_mask_out, average_load, zero fill
    output logic [chg_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [chg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [chg_pkg::PRIOS_W-1:0]   cfg_data
);

    chg_pkg::chg_cmd_t cmd;
    chg_pkg::chg_sts_t sts;

    assign cfg_ready = 1'b1;

    chg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    chg_datapath #(
        .NUM_CORES (NUM_CORES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
